// ----- sv/mbdpc_pkg.sv -----
// package for the multi-button debounce and press classifier
// types, register codes, field widths and reset values shared by all modules
`default_nettype none
package mbdpc_pkg;

    // field widths fixed by the stream format
    localparam int NOW_W      = 32;
    localparam int CNT_W      = 17;
    localparam int IDX_W      = 2;
    localparam int IDX_SPAN   = 4;
    localparam int LIMIT_W    = 16;
    localparam int STEP_W     = 8;
    localparam int LONG_W     = 16;
    localparam int EV_W       = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 2'd2;

    localparam logic [LIMIT_W-1:0] RST_DEBOUNCE_LIMIT = 16'd20;
    localparam logic [STEP_W-1:0]  RST_SAMPLE_STEP    = 8'd10;
    localparam logic [LONG_W-1:0]  RST_LONG_PRESS     = 16'd2000;

    // item kinds carried in tuser
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FETCH  = 1'b1;

    // result beat: event_res, any_pressed, max_press_ms
    localparam int OUT_W       = EV_W + 1 + NOW_W;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

    typedef enum logic [EV_W-1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } t_event;

    typedef struct packed {
        logic [LIMIT_W-1:0] debounce_limit;
        logic [STEP_W-1:0]  sample_step;
        logic [LONG_W-1:0]  long_press;
    } t_cfg;

    // what one button lane reports after the current beat
    typedef struct packed {
        logic             pressed;
        logic [NOW_W-1:0] held;
        t_event           evt;
    } t_lane_stat;

endpackage
`default_nettype wire

// ----- sv/mbdpc_lane.sv -----
// one button lane: debounce counter, stable level, press timing, latched event
// depends on mbdpc_pkg
`default_nettype none
module mbdpc_lane (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire mbdpc_pkg::t_cfg    i_cfg,
    input  wire                     i_upd,
    input  wire                     i_clr,
    input  wire                     i_raw,
    input  wire [mbdpc_pkg::NOW_W-1:0] i_now,
    output mbdpc_pkg::t_lane_stat   o_stat
);
    import mbdpc_pkg::*;

    logic             r_stable;
    logic             r_prev;
    logic [CNT_W-1:0] r_cnt;
    logic [NOW_W-1:0] r_start;
    t_event           r_evt;

    logic             n_stable;
    logic             n_prev;
    logic [CNT_W-1:0] n_cnt;
    logic [NOW_W-1:0] n_start;
    t_event           n_evt;

    logic [CNT_W-1:0] w_limit;
    logic [NOW_W-1:0] w_since;
    logic             w_settled;
    logic             w_press;
    logic             w_release;

    assign w_limit = {1'b0, i_cfg.debounce_limit};
    assign w_since = i_now - r_start;

    always_comb begin
        n_cnt     = r_cnt;
        n_prev    = r_prev;
        n_stable  = r_stable;
        n_start   = r_start;
        n_evt     = r_evt;
        w_settled = 1'b0;
        w_press   = 1'b0;
        w_release = 1'b0;
        if (i_upd) begin
            if (i_raw == r_prev) begin
                if (r_cnt < w_limit) begin
                    n_cnt = r_cnt + CNT_W'(i_cfg.sample_step);
                end
            end else begin
                n_cnt = '0;
            end
            n_prev    = i_raw;
            w_settled = (n_cnt >= w_limit);
            if (w_settled) begin
                n_stable  = i_raw;
                w_press   = r_stable & ~i_raw;
                w_release = ~r_stable & i_raw;
            end
            if (w_press) begin
                n_start = i_now;
            end else if (w_release) begin
                n_start = '0;
                n_evt   = (w_since >= NOW_W'(i_cfg.long_press)) ? EV_LONG : EV_SHORT;
            end
        end else if (i_clr) begin
            n_evt = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_prev   <= 1'b1;
            r_cnt    <= '0;
            r_start  <= '0;
            r_evt    <= EV_NONE;
        end else begin
            r_stable <= n_stable;
            r_prev   <= n_prev;
            r_cnt    <= n_cnt;
            r_start  <= n_start;
            r_evt    <= n_evt;
        end
    end

    // hold time after this beat; a fresh press or a zero start counts as none
    always_comb begin
        o_stat.pressed = ~n_stable;
        o_stat.held    = (~n_stable && (r_start != '0) && !w_press) ? w_since : '0;
        o_stat.evt     = r_evt;
    end

endmodule
`default_nettype wire

// ----- sv/mbdpc_merge.sv -----
// merge stage: registered max tree over lane hold times, carries event and flag
// depends on mbdpc_pkg; the last tree level is the output register
`default_nettype none
module mbdpc_merge #(
    parameter int BUTTONS = 4
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_vld,
    output logic                       o_rdy,
    input  wire [mbdpc_pkg::NOW_W-1:0] i_held [BUTTONS],
    input  wire                        i_any,
    input  wire mbdpc_pkg::t_event     i_ev,
    output logic                       o_vld,
    input  wire                        i_out_rdy,
    output logic [mbdpc_pkg::NOW_W-1:0] o_max,
    output logic                       o_any,
    output mbdpc_pkg::t_event          o_ev
);
    import mbdpc_pkg::*;

    localparam int LEVELS = (BUTTONS > 1) ? $clog2(BUTTONS) : 0;
    localparam int LEAVES = 1 << LEVELS;

    logic [NOW_W-1:0] w_leaf [LEAVES];
    logic [NOW_W-1:0] r_max  [LEVELS+1][LEAVES];
    logic             r_any  [LEVELS+1];
    t_event           r_ev   [LEVELS+1];
    logic [LEVELS:0]  r_vld;
    logic [LEVELS:0]  w_rdy;
    logic [LEVELS:0]  w_vin;

    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
        if (j < BUTTONS) begin : g_used
            assign w_leaf[j] = i_held[j];
        end else begin : g_pad
            assign w_leaf[j] = '0;
        end
    end

    // a stage loads when it is empty or its contents move on
    always_comb begin
        w_rdy[LEVELS] = !r_vld[LEVELS] || i_out_rdy;
        for (int k = LEVELS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
        w_vin[0] = i_vld;
        for (int k = 1; k <= LEVELS; k++) begin
            w_vin[k] = r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k <= LEVELS; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= w_vin[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && w_vin[0]) begin
            for (int j = 0; j < LEAVES; j++) begin
                r_max[0][j] <= w_leaf[j];
            end
            r_any[0] <= i_any;
            r_ev[0]  <= i_ev;
        end
        for (int k = 1; k <= LEVELS; k++) begin
            if (w_rdy[k] && w_vin[k]) begin
                for (int j = 0; j < LEAVES / 2; j++) begin
                    if (j < (LEAVES >> k)) begin
                        r_max[k][j] <= (r_max[k-1][2*j] >= r_max[k-1][2*j+1]) ?
                                       r_max[k-1][2*j] : r_max[k-1][2*j+1];
                    end
                end
                r_any[k] <= r_any[k-1];
                r_ev[k]  <= r_ev[k-1];
            end
        end
    end

    assign o_rdy = w_rdy[0];
    assign o_vld = r_vld[LEVELS];
    assign o_max = r_max[LEVELS][0];
    assign o_any = r_any[LEVELS];
    assign o_ev  = r_ev[LEVELS];

endmodule
`default_nettype wire

// ----- sv/multi_button_debounce_press_classifier_top.sv -----
// top level of the multi-button debounce and short/long press classifier
// depends on mbdpc_pkg, mbdpc_lane and mbdpc_merge
//
// Debounces BUTTONS active-low buttons and classifies each release as a short
// or a long press. Every input beat gives exactly one result beat. A sample
// beat (tuser = 0) carries the raw levels and the current millisecond time;
// each button has its own lane that updates its debounce counter, stable
// level, press start time and latched event in the cycle the beat is taken.
// A fetch beat (tuser = 1) returns the latched event of one button and clears
// it; an index at or above BUTTONS returns no event. Each result also reports
// whether any button is held and the longest current hold time, found by a
// registered max tree over the lanes. One beat is taken every cycle while the
// output side keeps up; each result passes through the leaf register and every
// level of the max tree before it appears. Bubbles in the tree are squeezed
// out, so while a finished result waits at the output the input stays ready
// until every tree stage holds a beat. Configuration writes land at once and
// are meant for times when no beat is in flight.
`default_nettype none
module multi_button_debounce_press_classifier_top #(
    parameter int BUTTONS = 4
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input stream
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // now_ms[31:0], raw_levels[32 +: BUTTONS], button_index, zero fill
    input  wire [(((mbdpc_pkg::NOW_W + BUTTONS + mbdpc_pkg::IDX_W) + 7) / 8) * 8 - 1:0]
                                i_s_axis_tdata,
    // mode[0]
    input  wire [0:0]           i_s_axis_tuser,
    // result stream
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    // event_res[1:0], any_pressed[2], max_press_ms[34:3], zero fill
    output logic [mbdpc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // configuration writes
    input  wire                 i_cfg_we,
    input  wire [mbdpc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [mbdpc_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import mbdpc_pkg::*;

    // register file: limit, step and long-press threshold
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit <= RST_DEBOUNCE_LIMIT;
            r_cfg.sample_step    <= RST_SAMPLE_STEP;
            r_cfg.long_press     <= RST_LONG_PRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_DEBOUNCE_LIMIT: r_cfg.debounce_limit <= i_cfg_wdata[LIMIT_W-1:0];
                REG_SAMPLE_STEP:    r_cfg.sample_step    <= i_cfg_wdata[STEP_W-1:0];
                REG_LONG_PRESS:     r_cfg.long_press     <= i_cfg_wdata[LONG_W-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // unpack the input beat
    logic               w_mode;
    logic [NOW_W-1:0]   w_now;
    logic [BUTTONS-1:0] w_raw;
    logic [IDX_W-1:0]   w_idx;

    assign w_mode = i_s_axis_tuser[0];
    assign w_now  = i_s_axis_tdata[NOW_W-1:0];
    assign w_raw  = i_s_axis_tdata[NOW_W +: BUTTONS];
    assign w_idx  = i_s_axis_tdata[NOW_W + BUTTONS +: IDX_W];

    logic w_accept;
    logic w_sample;
    logic w_fetch;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_sample = w_accept && (w_mode == MODE_SAMPLE);
    assign w_fetch  = w_accept && (w_mode == MODE_FETCH);

    // one lane per button
    t_lane_stat         w_stat [BUTTONS];
    logic [NOW_W-1:0]   w_held [BUTTONS];
    logic [BUTTONS-1:0] w_pressed;
    logic [BUTTONS-1:0] w_clr;

    for (genvar g = 0; g < BUTTONS; g++) begin : g_lane
        // only the buttons the index field can name are ever fetched
        if (g < IDX_SPAN) begin : g_fetchable
            assign w_clr[g] = w_fetch && (w_idx == IDX_W'(g));
        end else begin : g_unreachable
            assign w_clr[g] = 1'b0;
        end

        mbdpc_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (r_cfg),
            .i_upd   (w_sample),
            .i_clr   (w_clr[g]),
            .i_raw   (w_raw[g]),
            .i_now   (w_now),
            .o_stat  (w_stat[g])
        );

        assign w_held[g]    = w_stat[g].held;
        assign w_pressed[g] = w_stat[g].pressed;
    end

    // event picked by a fetch, none for a missing button or a sample beat
    t_event w_fetch_ev [IDX_SPAN];
    t_event w_ev;

    for (genvar j = 0; j < IDX_SPAN; j++) begin : g_fetch_ev
        if (j < BUTTONS) begin : g_present
            assign w_fetch_ev[j] = w_stat[j].evt;
        end else begin : g_absent
            assign w_fetch_ev[j] = EV_NONE;
        end
    end

    assign w_ev = (w_mode == MODE_FETCH) ? w_fetch_ev[w_idx] : EV_NONE;

    // max tree and output register
    logic [NOW_W-1:0] w_max;
    logic             w_any;
    t_event           w_out_ev;

    mbdpc_merge #(
        .BUTTONS (BUTTONS)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (i_s_axis_tvalid),
        .o_rdy     (o_s_axis_tready),
        .i_held    (w_held),
        .i_any     (|w_pressed),
        .i_ev      (w_ev),
        .o_vld     (o_m_axis_tvalid),
        .i_out_rdy (i_m_axis_tready),
        .o_max     (w_max),
        .o_any     (w_any),
        .o_ev      (w_out_ev)
    );

    assign o_m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, w_max, w_any, w_out_ev};

endmodule
`default_nettype wire

// ----- sv/mbdpc_checker.sv -----
// port-level checks for the press classifier, bound to the top level
// depends on mbdpc_pkg and multi_button_debounce_press_classifier_top
`default_nettype none
module mbdpc_checker (
    input wire                                i_clk,
    input wire                                i_rst_n,
    input wire                                o_s_axis_tready,
    input wire                                o_m_axis_tvalid,
    input wire                                i_m_axis_tready,
    input wire [mbdpc_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import mbdpc_pkg::*;

    // a waiting result beat stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result beat dropped while stalled");

    // with the output empty every tree stage can load, so input must be ready
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input not ready with empty output");

    // a hold time only exists while some button is held
    a_hold_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata[NOW_W+EV_W:EV_W+1] != '0)
            |-> o_m_axis_tdata[EV_W])
        else $error("hold time without a pressed button");

    // the event code is none, short or long
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[EV_W-1:0] == EV_NONE)
            || (o_m_axis_tdata[EV_W-1:0] == EV_SHORT)
            || (o_m_axis_tdata[EV_W-1:0] == EV_LONG))
        else $error("bad event code");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat valid after reset");

endmodule

bind multi_button_debounce_press_classifier_top mbdpc_checker u_mbdpc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
`default_nettype wire
